>>> rtl/hid_keyboard_report_builder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HID keyboard report builder
// Concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH
`define HID_KEYBOARD_REPORT_BUILDER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked property that is switched off while reset is high.
`define HKRB_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define HKRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HKRB_ASSERT_RST(lbl, clk, rst, prop, msg)
`define HKRB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/hkrb_pkg.sv
// ----------------------------------------------------------------------------
// HID keyboard report builder package
// Shared codes, report type, command and status bundles, consumer usage map.
// ----------------------------------------------------------------------------
package hkrb_pkg;

   localparam int SLOT_PORTS        = 6;
   localparam int KEY_SLOTS_DEFAULT = 6;

   localparam logic [1:0] REQ_KEY   = 2'd0;
   localparam logic [1:0] REQ_TAP   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic KIND_KEYBOARD = 1'b0;
   localparam logic KIND_CONSUMER = 1'b1;

   localparam logic [7:0] CONSUMER_FIRST = 8'hE8;
   localparam logic [7:0] CONSUMER_LAST  = 8'hFB;

   // Codes 0xEC, 0xF0, 0xF5, 0xF6, 0xF7 and 0xF9 carry no usage.
   localparam logic [9:0] USAGE_MAP [20] = '{
      10'h0CD, 10'h0B7, 10'h0B6, 10'h0B5, 10'h000,
      10'h0E9, 10'h0EA, 10'h0E2, 10'h000, 10'h224,
      10'h225, 10'h226, 10'h221, 10'h000, 10'h000,
      10'h000, 10'h032, 10'h000, 10'h227, 10'h192
   };

   typedef struct packed {
      logic                             kind;
      logic [7:0]                       modifier;
      logic [SLOT_PORTS-1:0][7:0]       slots;
      logic [9:0]                       usage;
      logic                             last;
   } report_type;

   typedef struct packed {
      logic accept;
      logic load_second;
   } cmd_type;

   typedef struct packed {
      logic [1:0] result_count;
   } status_type;

   function automatic logic [9:0] usage_of(input logic [7:0] code);
      logic [7:0] offset;
      offset = code - CONSUMER_FIRST;
      if ((code < CONSUMER_FIRST) || (code > CONSUMER_LAST)) begin
         return 10'd0;
      end
      return USAGE_MAP[offset[4:0]];
   endfunction

endpackage

>>> rtl/hkrb_ctrl.sv
// ----------------------------------------------------------------------------
// HID keyboard report builder controller
// Handshake sequencing: accepts requests and issues the second report of taps.
// ----------------------------------------------------------------------------
`include "hid_keyboard_report_builder_unit_defines.svh"

module hkrb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  hkrb_pkg::status_type status,
   output hkrb_pkg::cmd_type    cmd
);
   import hkrb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SECOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new beat if it is empty or drains now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.accept      = (state_ff == ST_IDLE) && req_valid && out_free;
      cmd.load_second = (state_ff == ST_SECOND) && out_free;
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               rsp_valid_in = (status.result_count != 2'd0);
               if (status.result_count == 2'd2) begin
                  state_in = ST_SECOND;
               end
            end
         end
         ST_SECOND: begin
            if (cmd.load_second) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign rsp_valid = rsp_valid_ff;

   `HKRB_ASSERT_RST(a_second_has_first, clock, reset,
      (state_ff == ST_SECOND) |-> rsp_valid_ff, "first report missing before second")
   `HKRB_ASSERT_RST(a_result_shown, clock, reset,
      (cmd.accept && (status.result_count != 2'd0)) |=> rsp_valid_ff,
      "accepted request with results shows no report")
   `HKRB_ASSERT_RST(a_tap_goes_second, clock, reset,
      (cmd.accept && (status.result_count == 2'd2)) |=> (state_ff == ST_SECOND),
      "two-report request did not schedule its second report")
   `HKRB_ASSERT_ALWAYS(a_cmd_exclusive, clock,
      !(cmd.accept && cmd.load_second), "accept and second load in one cycle")

endmodule

>>> rtl/hkrb_datapath.sv
// ----------------------------------------------------------------------------
// HID keyboard report builder datapath
// Key slot registers, request decode and the registered report.
// ----------------------------------------------------------------------------
module hkrb_datapath #(
   parameter int KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_type,
   input  logic [7:0]            key_code,
   input  logic                  is_press,
   input  logic [7:0]            mod_bits,
   input  logic                  host_ready,
   input  hkrb_pkg::cmd_type     cmd,
   output hkrb_pkg::status_type  status,
   output hkrb_pkg::report_type  report
);
   import hkrb_pkg::*;

   logic [7:0] key_slots_ff [KEY_SLOTS];
   logic [7:0] key_slots_in [KEY_SLOTS];
   logic [7:0] fill_slots   [KEY_SLOTS];
   logic [7:0] rel_slots    [KEY_SLOTS];
   report_type report_ff, report_in, first_rep;
   logic       second_kind_ff, second_kind_in;
   logic [9:0] usage;
   logic       is_consumer;
   logic       duplicate;
   logic       filled;

   assign usage       = usage_of(key_code);
   assign is_consumer = (usage != 10'd0);

   // Slot searches: duplicate check, first empty slot, release matches.
   always_comb begin
      duplicate = 1'b0;
      filled    = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         fill_slots[i] = key_slots_ff[i];
         rel_slots[i]  = (key_slots_ff[i] == key_code) ? 8'd0 : key_slots_ff[i];
         if (key_slots_ff[i] == key_code) begin
            duplicate = 1'b1;
         end
         if (!filled && (key_slots_ff[i] == 8'd0)) begin
            fill_slots[i] = key_code;
            filled        = 1'b1;
         end
      end
   end

   always_comb begin
      key_slots_in        = key_slots_ff;
      second_kind_in      = KIND_KEYBOARD;
      status.result_count = 2'd0;
      first_rep           = '0;
      first_rep.last      = 1'b1;
      case (req_type)
         REQ_CLEAR: begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
               key_slots_in[i] = 8'd0;
            end
            status.result_count = host_ready ? 2'd1 : 2'd0;
         end
         REQ_TAP: begin
            status.result_count = host_ready ? 2'd2 : 2'd0;
            second_kind_in      = is_consumer;
            first_rep.last      = 1'b0;
            if (is_consumer) begin
               first_rep.kind  = KIND_CONSUMER;
               first_rep.usage = usage;
            end else begin
               first_rep.modifier = mod_bits;
               first_rep.slots[0] = key_code;
            end
         end
         REQ_KEY: begin
            if (!host_ready) begin
               status.result_count = 2'd0;
            end else if (is_consumer) begin
               status.result_count = 2'd1;
               first_rep.kind      = KIND_CONSUMER;
               first_rep.usage     = is_press ? usage : 10'd0;
            end else if (is_press) begin
               if (!duplicate) begin
                  status.result_count = 2'd1;
                  key_slots_in        = fill_slots;
                  first_rep.modifier  = mod_bits;
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     first_rep.slots[i] = fill_slots[i];
                  end
               end
            end else begin
               status.result_count = 2'd1;
               key_slots_in        = rel_slots;
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  first_rep.slots[i] = rel_slots[i];
               end
            end
         end
         default: begin
            status.result_count = 2'd0;
         end
      endcase
   end

   always_comb begin
      report_in = report_ff;
      if (cmd.accept) begin
         report_in = first_rep;
      end else if (cmd.load_second) begin
         report_in      = '0;
         report_in.kind = second_kind_ff;
         report_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_SLOTS; i++) begin
            key_slots_ff[i] <= 8'd0;
         end
      end else if (cmd.accept) begin
         key_slots_ff <= key_slots_in;
      end
   end

   always_ff @(posedge clock) begin
      report_ff <= report_in;
      if (cmd.accept) begin
         second_kind_ff <= second_kind_in;
      end
   end

   assign report = report_ff;

endmodule

>>> rtl/hid_keyboard_report_builder_unit.sv
// ----------------------------------------------------------------------------
// HID keyboard report builder
// Six-key-rollover keyboard and consumer-control report generator.
// ----------------------------------------------------------------------------
// Each request beat (key event, tap or clear) is decoded in the cycle it is
// accepted: the key slots update at that edge and the first report, if any,
// is registered for the rsp_ channel. Key events and clears give at most one
// report, so a new request is taken every cycle while the output register is
// empty or being drained. A tap gives a press report and then a release
// report; the release report is loaded from the controller's second state,
// so a tap holds the request channel until that report is loaded. Throughput is
// set by the single output register: one report beat per cycle when rsp_stall
// stays low. When req_host_ready is low nothing is reported and only a clear
// changes the slots. Slots at or above KEY_SLOTS always read as zero in
// reports.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_unit #(
   parameter int KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_key_code,
   input  logic       req_is_press,
   input  logic [7:0] req_mod_bits,
   input  logic       req_host_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_report_kind,
   output logic [7:0] rsp_mod_out,
   output logic [7:0] rsp_slot_a,
   output logic [7:0] rsp_slot_b,
   output logic [7:0] rsp_slot_c,
   output logic [7:0] rsp_slot_d,
   output logic [7:0] rsp_slot_e,
   output logic [7:0] rsp_slot_f,
   output logic [9:0] rsp_consumer_usage,
   output logic       rsp_last_of_run
);
   import hkrb_pkg::*;

   cmd_type    cmd;
   status_type status;
   report_type report;

   // The controller owns the handshakes and the valid flag of the report.
   hkrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the key slots and the registered report payload.
   hkrb_datapath #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_type   (req_type),
      .key_code   (req_key_code),
      .is_press   (req_is_press),
      .mod_bits   (req_mod_bits),
      .host_ready (req_host_ready),
      .cmd        (cmd),
      .status     (status),
      .report     (report)
   );

   // Report fields map one to one onto the result ports.
   assign rsp_report_kind    = report.kind;
   assign rsp_mod_out        = report.modifier;
   assign rsp_slot_a         = report.slots[0];
   assign rsp_slot_b         = report.slots[1];
   assign rsp_slot_c         = report.slots[2];
   assign rsp_slot_d         = report.slots[3];
   assign rsp_slot_e         = report.slots[4];
   assign rsp_slot_f         = report.slots[5];
   assign rsp_consumer_usage = report.usage;
   assign rsp_last_of_run    = report.last;

endmodule
